// ===== rtl/r2p_pkg.sv =====
// Shared constants, types and tables for the rect_to_polar CORDIC.
// Used by every module in rtl/. No dependencies.
package r2p_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int ITERATIONS      = 16;
  localparam int GUARD           = 8;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int CELLS = (ITERATIONS < ANGLE_TABLE_LEN) ? ITERATIONS : ANGLE_TABLE_LEN;
  localparam int ATW             = $clog2(ANGLE_TABLE_LEN);
  localparam int XW              = DATA_WIDTH + GUARD + 2;
  localparam int AW              = 32;
  localparam int GAIN_W          = 30;
  localparam int ANG_SH          = AW - DATA_WIDTH;

  typedef logic [AW-1:0] angle_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam angle_t ANGLE_PI      = 32'h8000_0000;
  localparam angle_t ANGLE_HALF_PI = 32'h4000_0000;
  localparam logic [AW:0] ANG_RND  = (33'd1 << ANG_SH) >> 1;

  typedef struct packed {
    logic                 valid;
    logic                 special;
    word_t                spec_mag;
    word_t                spec_ang;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    angle_t               acc;
  } stage_t;

  // atan(2^-i), 2^32 per full turn
  function automatic angle_t atan_val(input logic [ATW-1:0] i);
    angle_t v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680862;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41721;
      5'd15:   v = 32'd20860;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2607;
      5'd19:   v = 32'd1303;
      5'd20:   v = 32'd651;
      5'd21:   v = 32'd325;
      5'd22:   v = 32'd162;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up to DATA_WIDTH bits, wrapping
  function automatic word_t angle_round(input angle_t acc);
    logic [AW:0] s;
    s = ({1'b0, acc} + ANG_RND) >> ANG_SH;
    return s[DATA_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/r2p_prep.sv =====
// Input stage: axis/zero detection and left-half-plane fold.
// Depends on r2p_pkg.
module r2p_prep (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [r2p_pkg::DATA_WIDTH-1:0] real_part,
  input  logic [r2p_pkg::DATA_WIDTH-1:0] imag_part,
  output r2p_pkg::stage_t          out
);
  import r2p_pkg::*;

  stage_t nxt;

  always_comb begin
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic re_zero;
    logic im_zero;
    re = real_part;
    im = imag_part;
    re_zero = (re == '0);
    im_zero = (im == '0);
    xs = XW'(re) <<< GUARD;
    ys = XW'(im) <<< GUARD;
    nxt.valid   = start;
    nxt.special = re_zero || im_zero;
    if (im_zero) begin
      nxt.spec_mag = re[DATA_WIDTH-1] ? word_t'(-re) : word_t'(re);
      nxt.spec_ang = re[DATA_WIDTH-1] ? angle_round(ANGLE_PI) : '0;
    end else begin
      nxt.spec_mag = im[DATA_WIDTH-1] ? word_t'(-im) : word_t'(im);
      nxt.spec_ang = im[DATA_WIDTH-1] ? angle_round(angle_t'(0) - ANGLE_HALF_PI)
                                      : angle_round(ANGLE_HALF_PI);
    end
    if (re[DATA_WIDTH-1]) begin
      nxt.x   = -xs;
      nxt.y   = -ys;
      nxt.acc = ANGLE_PI;
    end else begin
      nxt.x   = xs;
      nxt.y   = ys;
      nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    out.special  <= nxt.special;
    out.spec_mag <= nxt.spec_mag;
    out.spec_ang <= nxt.spec_ang;
    out.x        <= nxt.x;
    out.y        <= nxt.y;
    out.acc      <= nxt.acc;
  end

endmodule

// ===== rtl/r2p_cell.sv =====
// One CORDIC vectoring micro-rotation, registered.
// Depends on r2p_pkg; step selects shift and angle table entry.
module r2p_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [r2p_pkg::ATW-1:0] step,
  input  r2p_pkg::stage_t        in,
  output r2p_pkg::stage_t        out
);
  import r2p_pkg::*;

  stage_t nxt;

  always_comb begin
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    angle_t da;
    dx  = in.y >>> step;
    dy  = in.x >>> step;
    da  = atan_val(step);
    nxt = in;
    if (!in.y[XW-1]) begin
      nxt.x   = in.x + dx;
      nxt.y   = in.y - dy;
      nxt.acc = in.acc + da;
    end else begin
      nxt.x   = in.x - dx;
      nxt.y   = in.y + dy;
      nxt.acc = in.acc - da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    out.special  <= nxt.special;
    out.spec_mag <= nxt.spec_mag;
    out.spec_ang <= nxt.spec_ang;
    out.x        <= nxt.x;
    out.y        <= nxt.y;
    out.acc      <= nxt.acc;
  end

endmodule

// ===== rtl/r2p_gain.sv =====
// Output stages: CORDIC gain correction (two partial products), rounding,
// saturation and axis-case select. Depends on r2p_pkg.
module r2p_gain (
  input  logic                           clk,
  input  logic                           rst,
  input  r2p_pkg::stage_t                in,
  output logic                           done,
  output logic [r2p_pkg::DATA_WIDTH-1:0] magnitude,
  output logic [r2p_pkg::DATA_WIDTH-1:0] phase_angle
);
  import r2p_pkg::*;

  localparam int HI_W   = XW - 16;
  localparam int PLO_W  = 16 + GAIN_W + 1;
  localparam int PHI_W  = HI_W + GAIN_W;
  localparam int T_W    = PLO_W - 16;
  localparam int MW     = PHI_W + 1;
  localparam int MAG_SH = GAIN_W + GUARD - 16;
  localparam logic [PLO_W-1:0] LO_RND = PLO_W'(1) << (GAIN_W + GUARD - 1);

  typedef struct packed {
    logic             valid;
    logic             special;
    word_t            spec_mag;
    word_t            spec_ang;
    word_t            ang;
    logic [PLO_W-1:0] p_lo;
    logic [PHI_W-1:0] p_hi;
  } prod_t;

  prod_t s1;
  logic  done_next;
  word_t mag_next;
  word_t ang_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [XW-1:0] xm;
    xm = in.x;
    s1.special  <= in.special;
    s1.spec_mag <= in.spec_mag;
    s1.spec_ang <= in.spec_ang;
    s1.ang      <= angle_round(in.acc);
    s1.p_lo     <= PLO_W'(xm[15:0]) * PLO_W'(GAIN_Q30);
    s1.p_hi     <= PHI_W'(xm[XW-1:16]) * PHI_W'(GAIN_Q30);
  end

  always_comb begin
    logic [PLO_W-1:0] lo_r;
    logic [T_W-1:0]   t;
    logic [MW-1:0]    sum;
    logic [MW-1:0]    q;
    lo_r = s1.p_lo + LO_RND;
    t    = lo_r[PLO_W-1:16];
    sum  = MW'(s1.p_hi) + MW'(t);
    q    = sum >> MAG_SH;
    done_next = s1.valid;
    if (s1.special) begin
      mag_next = s1.spec_mag;
      ang_next = s1.spec_ang;
    end else begin
      mag_next = (|q[MW-1:DATA_WIDTH]) ? '1 : q[DATA_WIDTH-1:0];
      ang_next = s1.ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    magnitude   <= mag_next;
    phase_angle <= ang_next;
  end

endmodule

// ===== rtl/rect_to_polar.sv =====
// rect_to_polar: Cartesian to polar conversion by a pipelined CORDIC.
// Depends on r2p_pkg, r2p_prep, r2p_cell, r2p_gain.
//
// Usage:
//   A sample word (real_part, imag_part, signed) is taken at every rising
//   edge where start is high and busy is low. busy is held low: the
//   pipeline takes a new word every cycle.
//   Each word yields one result (magnitude unsigned, phase_angle signed in
//   units of pi/2^(DATA_WIDTH-1), pi reads as the most negative code),
//   shown for one cycle with done high.
//   Pipeline: one input stage, one cell per micro-rotation, two
//   gain-correction stages (the gain multiply is split into two partial
//   products and summed in the last stage).
//   Throughput: one word per cycle, set by the fully unrolled cell chain.
//   Results leave in input order; the receiver cannot stall, so done
//   pulses must be captured when they occur.
//   Reset (rst, synchronous) flushes all valid flags; words in flight are
//   dropped and no done pulse follows until new words arrive.
module rect_to_polar (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [r2p_pkg::DATA_WIDTH-1:0] real_part,
  input  logic [r2p_pkg::DATA_WIDTH-1:0] imag_part,
  output logic                           done,
  output logic [r2p_pkg::DATA_WIDTH-1:0] magnitude,
  output logic [r2p_pkg::DATA_WIDTH-1:0] phase_angle
);
  import r2p_pkg::*;

  stage_t chain [CELLS+1];

  assign busy = 1'b0;

  r2p_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .real_part (real_part),
    .imag_part (imag_part),
    .out       (chain[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    r2p_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (ATW'(i)),
      .in   (chain[i]),
      .out  (chain[i+1])
    );
  end

  r2p_gain u_gain (
    .clk         (clk),
    .rst         (rst),
    .in          (chain[CELLS]),
    .done        (done),
    .magnitude   (magnitude),
    .phase_angle (phase_angle)
  );

endmodule
